### rtl/upg_pkg.sv
// shared constants, fixed-point helpers and the exp factor table for the pixel grade pipeline
// no dependencies; imported by upg_atten and underwater_pixel_grade
`default_nettype none

package upg_pkg;

  localparam int unsigned FRAC_BITS = 14;
  localparam int unsigned ONE       = 1 << FRAC_BITS;
  localparam int unsigned QW        = FRAC_BITS + 1;   // holds 0..ONE
  localparam int unsigned MAX_ROWS  = 4096;
  localparam int unsigned EXP_TERMS = 22;
  localparam int unsigned ATTN_SCALE = 15565;          // 3.8 in Q12

  // register map, index = paddr / 4
  localparam logic [2:0] REG_MAX_DEPTH    = 3'd0;
  localparam logic [2:0] REG_ATTN_GAIN    = 3'd1;
  localparam logic [2:0] REG_WATER_BLUE   = 3'd2;
  localparam logic [2:0] REG_WATER_GREEN  = 3'd3;
  localparam logic [2:0] REG_WATER_RED    = 3'd4;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd5;

  // depth source codes
  localparam logic [1:0] SRC_MEASURED = 2'd0;
  localparam logic [1:0] SRC_INVALID  = 2'd1;
  localparam logic [1:0] SRC_ROWS     = 2'd2;

  // fixed-point constants, rounded to nearest
  localparam logic [16:0] K_VERT     = 17'((7 * ONE + 5) / 10);
  localparam logic [16:0] K_BR_TOP   = 17'((185 * ONE + 50) / 100);
  localparam logic [16:0] K_BR_BOT   = 17'((105 * ONE + 50) / 100);
  localparam logic [16:0] K_BR_DEPTH = 17'((40 * ONE + 50) / 100);
  localparam logic [16:0] K_BR_MIN   = 17'((85 * ONE + 50) / 100);
  localparam logic [16:0] K_CT_DEPTH = 17'((10 * ONE + 50) / 100);
  localparam logic [16:0] K_CT_MIN   = 17'((7 * ONE + 5) / 10);
  localparam logic [16:0] K_DS_BASE  = 17'((12 * ONE + 50) / 100);
  localparam logic [16:0] K_DS_DEPTH = 17'((35 * ONE + 50) / 100);

  // per channel, blue green red
  localparam logic [16:0] K_LIGHT [3] = '{17'((32 * ONE + 5) / 10),
                                          17'((25 * ONE + 5) / 10),
                                          17'((15 * ONE + 5) / 10)};
  localparam logic [16:0] K_DARK  [3] = '{17'((11 * ONE + 5) / 10),
                                          17'((65 * ONE + 50) / 100),
                                          17'((25 * ONE + 50) / 100)};
  localparam logic [16:0] K_TINT_UP [3] = '{17'((128 * ONE + 50) / 100),
                                            17'((115 * ONE + 50) / 100),
                                            17'((100 * ONE + 50) / 100)};
  localparam logic [16:0] K_TINT_LO [3] = '{17'((118 * ONE + 50) / 100),
                                            17'((108 * ONE + 50) / 100),
                                            17'((92 * ONE + 50) / 100)};
  localparam logic [16:0] K_GRAY  [3] = '{17'((114 * ONE + 500) / 1000),
                                          17'((587 * ONE + 500) / 1000),
                                          17'((299 * ONE + 500) / 1000)};

  // exp(-2^k) in Q30, k from -16
  localparam logic [29:0] EXP_NEG_POW2 [EXP_TERMS] = '{
    30'd1073725440, 30'd1073709056, 30'd1073676290, 30'd1073610760, 30'd1073479712,
    30'd1073217664, 30'd1072693760, 30'd1071646719, 30'd1069555701, 30'd1065385899,
    30'd1057095000, 30'd1040706261, 30'd1008687096, 30'd947573834, 30'd836230973,
    30'd651257337, 30'd395007542, 30'd145315154, 30'd19666268, 30'd360200,
    30'd121, 30'd0};

  // fixed-point product, rounded half up
  function automatic logic [23:0] mq(input logic [23:0] a, input logic [16:0] b);
    logic [40:0] p;
    p = 41'(a) * 41'(b) + 41'(ONE / 2);
    return p[FRAC_BITS +: 24];
  endfunction

endpackage

`default_nettype wire

### rtl/underwater_pixel_grade.sv
// top level of the underwater pixel grade: register port, input capture, dividers and color path
// depends on upg_pkg, upg_div and upg_atten
`default_nettype none

// Grades one BGR pixel per clock while the pipeline advances. A pixel enters whenever
// s_axis_tready_o is high and its graded result passes through 1 capture stage, 15 divider
// stages (one quotient bit each), 41 stages for square root, attenuation multiplies and the
// 22-factor exp chain, and 10 color stages ending in the output register. The whole pipeline
// advances together; a low m_axis_tready_i holds every stage while the output register is
// full, so s_axis_tready_o follows m_axis_tready_i in that state. Registers are written over
// APB at byte address 4*index and should only change while no pixel is in flight.

module underwater_pixel_grade import upg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [4:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o,
  // pixel in
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,  // in_blue, in_green, in_red, depth_mm, row_index, pad
  input  logic [1:0]  s_axis_tuser_i,  // depth_source
  // pixel out
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o   // out_blue, out_green, out_red
);

  // ---------------- configuration ----------------
  logic [15:0] depth_lim_q, gain_q;
  logic [14:0] water_q [3];
  logic [12:0] frame_h_q;

  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_lim_q <= 16'd12000;
      gain_q      <= 16'd1229;
      water_q[0]  <= 15'd7864;
      water_q[1]  <= 15'd5734;
      water_q[2]  <= 15'd2458;
      frame_h_q   <= 13'd480;
    end else if (psel_i && penable_i && pwrite_i) begin
      unique case (paddr_i[4:2])
        REG_MAX_DEPTH:    depth_lim_q <= pwdata_i[15:0];
        REG_ATTN_GAIN:    gain_q      <= pwdata_i[15:0];
        REG_WATER_BLUE:   water_q[0]  <= pwdata_i[14:0];
        REG_WATER_GREEN:  water_q[1]  <= pwdata_i[14:0];
        REG_WATER_RED:    water_q[2]  <= pwdata_i[14:0];
        REG_FRAME_HEIGHT: frame_h_q   <= pwdata_i[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr_i[4:2])
      REG_MAX_DEPTH:    prdata_o = 32'(depth_lim_q);
      REG_ATTN_GAIN:    prdata_o = 32'(gain_q);
      REG_WATER_BLUE:   prdata_o = 32'(water_q[0]);
      REG_WATER_GREEN:  prdata_o = 32'(water_q[1]);
      REG_WATER_RED:    prdata_o = 32'(water_q[2]);
      REG_FRAME_HEIGHT: prdata_o = 32'(frame_h_q);
      default:          prdata_o = '0;
    endcase
  end

  logic [15:0] maxd;
  logic [12:0] rows;

  assign maxd = (depth_lim_q == '0) ? 16'd1 : depth_lim_q;
  always_comb begin
    if (frame_h_q == '0) begin
      rows = 13'd1;
    end else if (frame_h_q > 13'(MAX_ROWS)) begin
      rows = 13'(MAX_ROWS);
    end else begin
      rows = frame_h_q;
    end
  end

  // ---------------- pipeline control ----------------
  logic adv;
  logic out_vld_q;

  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = out_vld_q;

  // ---------------- capture ----------------
  logic [7:0]  in_ch [3];
  logic [15:0] depth_in, depth_c;
  logic [11:0] row_in;
  logic [12:0] row_c;
  logic [QW-1:0] px_in [3];

  assign in_ch[0] = s_axis_tdata_i[7:0];
  assign in_ch[1] = s_axis_tdata_i[15:8];
  assign in_ch[2] = s_axis_tdata_i[23:16];
  assign depth_in = s_axis_tdata_i[39:24];
  assign row_in   = s_axis_tdata_i[51:40];

  assign depth_c = (depth_in > maxd) ? maxd : depth_in;
  // a row at or past the bottom divides to exactly one
  assign row_c   = (13'(row_in) >= rows) ? rows : 13'(row_in);

  // x*ONE/255 rounded: 64x + floor((64x+127)/255)
  always_comb begin
    logic [14:0] y;
    logic [14:0] q;
    for (int c = 0; c < 3; c++) begin
      y = {1'b0, in_ch[c], 6'd0} + 15'd127;
      q = (y + (y >> 8) + 15'd1) >> 8;
      px_in[c] = QW'({in_ch[c], 6'd0}) + q;
    end
  end

  logic          s0_vld_q;
  logic [QW-1:0] s0_px_q [3];
  logic [30:0]   s0_numd_q;
  logic [27:0]   s0_numr_q;
  logic [1:0]    s0_src_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_px_q   <= px_in;
      s0_numd_q <= 31'({depth_c, {FRAC_BITS{1'b0}}}) + 31'(maxd >> 1);
      s0_numr_q <= 28'({row_c, {FRAC_BITS{1'b0}}}) + 28'(rows >> 1);
      s0_src_q  <= s_axis_tuser_i;
    end
  end

  // ---------------- dividers ----------------
  localparam int unsigned DSW = 3 * QW + 2;

  logic          dv_vld;
  logic [QW-1:0] dq, rq;
  logic [DSW-1:0] dv_side;

  upg_div #(.NW(31), .DW(16), .QB(QW), .SW(DSW)) u_div_depth (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s0_vld_q),
    .num_i  (s0_numd_q),
    .den_i  (maxd),
    .side_i ({s0_src_q, s0_px_q[2], s0_px_q[1], s0_px_q[0]}),
    .vld_o  (dv_vld),
    .quo_o  (dq),
    .side_o (dv_side)
  );

  upg_div #(.NW(28), .DW(13), .QB(QW), .SW(1)) u_div_row (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s0_vld_q),
    .num_i  (s0_numr_q),
    .den_i  (rows),
    .side_i (1'b0),
    .vld_o  (),
    .quo_o  (rq),
    .side_o ()
  );

  logic [1:0]    dv_src;
  logic [QW-1:0] dn, vert;
  logic [23:0]   vert_drop;

  assign dv_src    = dv_side[DSW-1 -: 2];
  assign vert_drop = mq(24'(rq), K_VERT);
  assign vert      = QW'(ONE) - vert_drop[QW-1:0];

  always_comb begin
    case (dv_src)
      SRC_INVALID: dn = '0;
      SRC_ROWS:    dn = rq;
      default:     dn = dq;
    endcase
  end

  // ---------------- depth term and attenuation ----------------
  localparam int unsigned ASW = 4 * QW;

  logic           at_vld;
  logic [QW-1:0]  at_d, at_a;
  logic [ASW-1:0] at_side;
  logic [QW-1:0]  at_px [3];
  logic [QW-1:0]  at_vert;

  upg_atten #(.SW(ASW)) u_atten (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (dv_vld),
    .dn_i   (dn),
    .gain_i (gain_q),
    .side_i ({dv_side[3*QW-1:0], vert}),
    .vld_o  (at_vld),
    .d_o    (at_d),
    .a_o    (at_a),
    .side_o (at_side)
  );

  assign at_vert  = at_side[QW-1:0];
  assign at_px[0] = at_side[QW +: QW];
  assign at_px[1] = at_side[2*QW +: QW];
  assign at_px[2] = at_side[3*QW +: QW];

  // ---------------- color path ----------------
  // one valid bit per stage p0..p8, the output register takes the last
  logic [8:0] vp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q      <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vp_q      <= {vp_q[7:0], at_vld};
      out_vld_q <= vp_q[8];
    end
  end

  // p0: products of depth and row terms
  logic [23:0]   p0_light_q [3], p0_dark_q [3], p0_up_q [3], p0_lo_q [3];
  logic [23:0]   p0_bhi_q, p0_blo_q, p0_bd_q, p0_cd_q, p0_dd_q;
  logic [QW-1:0] p0_d_q, p0_a_q, p0_px_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        p0_light_q[c] <= mq(24'(water_q[c]), K_LIGHT[c]);
        p0_dark_q[c]  <= mq(24'(water_q[c]), K_DARK[c]);
        p0_up_q[c]    <= mq(24'(K_TINT_UP[c]), 17'(at_vert));
        p0_lo_q[c]    <= mq(24'(K_TINT_LO[c]), 17'(QW'(ONE) - at_vert));
      end
      p0_bhi_q <= mq(24'(K_BR_TOP), 17'(at_vert));
      p0_blo_q <= mq(24'(K_BR_BOT), 17'(QW'(ONE) - at_vert));
      p0_bd_q  <= mq(24'(at_d), K_BR_DEPTH);
      p0_cd_q  <= mq(24'(at_d), K_CT_DEPTH);
      p0_dd_q  <= mq(24'(at_d), K_DS_DEPTH);
      p0_d_q   <= at_d;
      p0_a_q   <= at_a;
      p0_px_q  <= at_px;
    end
  end

  // p1: water blend terms, tints, brightness and contrast factors
  logic [23:0] bsum;
  logic [23:0] bright_c, contrast_c;

  assign bsum = p0_bhi_q + p0_blo_q;

  always_comb begin
    if (bsum < p0_bd_q + 24'(K_BR_MIN)) begin
      bright_c = 24'(K_BR_MIN);
    end else if (bsum - p0_bd_q > 24'(2 * ONE)) begin
      bright_c = 24'(2 * ONE);
    end else begin
      bright_c = bsum - p0_bd_q;
    end
    if (p0_cd_q >= 24'(ONE)) begin
      contrast_c = 24'(K_CT_MIN);
    end else if (24'(ONE) - p0_cd_q < 24'(K_CT_MIN)) begin
      contrast_c = 24'(K_CT_MIN);
    end else begin
      contrast_c = 24'(ONE) - p0_cd_q;
    end
  end

  logic [23:0]   p1_wl_q [3], p1_wd_q [3], p1_tint_q [3], p1_pa_q [3];
  logic [16:0]   p1_bright_q, p1_contrast_q, p1_desat_q;
  logic [QW-1:0] p1_inv_a_q, p1_off_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        p1_wl_q[c]   <= mq(p0_light_q[c], 17'(QW'(ONE) - p0_d_q));
        p1_wd_q[c]   <= mq(p0_dark_q[c], 17'(p0_d_q));
        p1_tint_q[c] <= p0_up_q[c] + p0_lo_q[c];
        p1_pa_q[c]   <= mq(24'(p0_px_q[c]), 17'(p0_a_q));
      end
      p1_bright_q   <= bright_c[16:0];
      p1_contrast_q <= contrast_c[16:0];
      p1_off_q      <= QW'((24'(ONE) - contrast_c + 24'd1) >> 1);
      p1_desat_q    <= 17'(K_DS_BASE + p0_dd_q[16:0]);
      p1_inv_a_q    <= QW'(ONE) - p0_a_q;
    end
  end

  // p2: water color weighted by one minus the transmitted share
  logic [23:0]   p2_pw_q [3], p2_pa_q [3], p2_tint_q [3];
  logic [16:0]   p2_bright_q, p2_contrast_q, p2_desat_q;
  logic [QW-1:0] p2_off_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        p2_pw_q[c] <= mq(p1_wl_q[c] + p1_wd_q[c], 17'(p1_inv_a_q));
      end
      p2_pa_q       <= p1_pa_q;
      p2_tint_q     <= p1_tint_q;
      p2_bright_q   <= p1_bright_q;
      p2_contrast_q <= p1_contrast_q;
      p2_desat_q    <= p1_desat_q;
      p2_off_q      <= p1_off_q;
    end
  end

  // p3: tint
  logic [23:0]   p3_pt_q [3];
  logic [16:0]   p3_bright_q, p3_contrast_q, p3_desat_q;
  logic [QW-1:0] p3_off_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        p3_pt_q[c] <= mq(p2_pa_q[c] + p2_pw_q[c], p2_tint_q[c][16:0]);
      end
      p3_bright_q   <= p2_bright_q;
      p3_contrast_q <= p2_contrast_q;
      p3_desat_q    <= p2_desat_q;
      p3_off_q      <= p2_off_q;
    end
  end

  // p4: brightness
  logic [23:0]   p4_pb_q [3];
  logic [16:0]   p4_contrast_q, p4_desat_q;
  logic [QW-1:0] p4_off_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        p4_pb_q[c] <= mq(p3_pt_q[c], p3_bright_q);
      end
      p4_contrast_q <= p3_contrast_q;
      p4_desat_q    <= p3_desat_q;
      p4_off_q      <= p3_off_q;
    end
  end

  // p5: contrast toward mid-grey
  logic [23:0] p5_px_q [3];
  logic [16:0] p5_desat_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        p5_px_q[c] <= mq(p4_pb_q[c], p4_contrast_q) + 24'(p4_off_q);
      end
      p5_desat_q <= p4_desat_q;
    end
  end

  // p6: grey weights
  logic [23:0] p6_g_q [3], p6_px_q [3];
  logic [16:0] p6_desat_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        p6_g_q[c] <= mq(p5_px_q[c], K_GRAY[c]);
      end
      p6_px_q    <= p5_px_q;
      p6_desat_q <= p5_desat_q;
    end
  end

  // p7: grey level and kept color
  logic [23:0] p7_gray_q, p7_mk_q [3];
  logic [16:0] p7_desat_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p7_gray_q <= p6_g_q[0] + p6_g_q[1] + p6_g_q[2];
      for (int c = 0; c < 3; c++) begin
        p7_mk_q[c] <= mq(p6_px_q[c], 17'(ONE) - p6_desat_q);
      end
      p7_desat_q <= p6_desat_q;
    end
  end

  // p8: grey share
  logic [23:0] p8_mg_q, p8_mk_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p8_mg_q <= mq(p7_gray_q, p7_desat_q);
      p8_mk_q <= p7_mk_q;
    end
  end

  // output register: scale to 8 bits, round and saturate
  logic [7:0] out_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 3; c++) begin
        logic [33:0] scaled;
        scaled = (34'(p8_mk_q[c] + p8_mg_q) * 34'd255 + 34'(ONE / 2)) >> FRAC_BITS;
        out_q[c] <= (scaled > 34'd255) ? 8'd255 : scaled[7:0];
      end
    end
  end

  assign m_axis_tdata_o = {out_q[2], out_q[1], out_q[0]};

endmodule

`default_nettype wire

### rtl/upg_div.sv
// pipelined restoring divider, one quotient bit per register stage, with sideband
// no package dependencies; instantiated by underwater_pixel_grade
`default_nettype none

module upg_div #(
  parameter int unsigned NW = 31,
  parameter int unsigned DW = 16,
  parameter int unsigned QB = 15,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [QB-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned CW = NW + DW;

  logic [NW-1:0] rem_q  [QB];
  logic [DW-1:0] den_q  [QB];
  logic [QB-1:0] quo_q  [QB];
  logic [SW-1:0] side_q [QB];
  logic          vld_q  [QB];

  for (genvar s = 0; s < QB; s++) begin : g_stage
    localparam int unsigned B = QB - 1 - s;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QB-1:0] quo_in;
    logic [SW-1:0] side_in;
    logic          vld_in;
    logic [CW-1:0] sub;

    if (s == 0) begin : g_first
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign side_in = side_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    assign sub = CW'(den_in) << B;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
        if (CW'(rem_in) >= sub) begin
          rem_q[s] <= rem_in - NW'(sub);
          quo_q[s] <= quo_in | (QB'(1) << B);
        end else begin
          rem_q[s] <= rem_in;
          quo_q[s] <= quo_in;
        end
      end
    end
  end

  assign vld_o  = vld_q[QB-1];
  assign quo_o  = quo_q[QB-1];
  assign side_o = side_q[QB-1];

endmodule

`default_nettype wire

### rtl/upg_atten.sv
// depth term and attenuation: rounded square root of the normalized depth, then
// exp(-gain*3.8*d) as a chain of table factors; depends on upg_pkg
`default_nettype none

module upg_atten import upg_pkg::*; #(
  parameter int unsigned SW = 60
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [QW-1:0] dn_i,
  input  logic [15:0]   gain_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [QW-1:0] d_o,
  output logic [QW-1:0] a_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned RW = 2 * FRAC_BITS + 2;
  localparam int unsigned TW = 2 * QW + 1;
  localparam int unsigned AW = 31;
  localparam int unsigned MW = 45;

  // square root, one result bit per stage
  logic [RW-1:0] sq_rem_q  [QW];
  logic [QW-1:0] sq_r_q    [QW];
  logic [SW-1:0] sq_side_q [QW];
  logic          sq_vld_q  [QW];

  for (genvar s = 0; s < QW; s++) begin : g_sqrt
    localparam int unsigned B = QW - 1 - s;
    logic [RW-1:0] rem_in;
    logic [QW-1:0] r_in;
    logic [SW-1:0] side_in;
    logic          vld_in;
    logic [TW-1:0] trial;

    if (s == 0) begin : g_first
      assign rem_in  = RW'({dn_i, {FRAC_BITS{1'b0}}});
      assign r_in    = '0;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = sq_rem_q[s-1];
      assign r_in    = sq_r_q[s-1];
      assign side_in = sq_side_q[s-1];
      assign vld_in  = sq_vld_q[s-1];
    end

    // (r + 2^b)^2 - r^2, the bits of r are all above b
    assign trial = (TW'(r_in) << (B + 1)) | (TW'(1) << (2 * B));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[s] <= 1'b0;
      end else if (en_i) begin
        sq_vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_side_q[s] <= side_in;
        if (TW'(rem_in) >= trial) begin
          sq_rem_q[s] <= rem_in - RW'(trial);
          sq_r_q[s]   <= r_in | (QW'(1) << B);
        end else begin
          sq_rem_q[s] <= rem_in;
          sq_r_q[s]   <= r_in;
        end
      end
    end
  end

  // round to nearest, then gain*d*3.8 in two multiplies
  logic [QW-1:0] rd_q, m1_dep_q, m2_dep_q;
  logic [SW-1:0] rd_side_q, m1_side_q, m2_side_q;
  logic          rd_vld_q, m1_vld_q, m2_vld_q;
  logic [AW-1:0] m1_q;
  logic [MW-1:0] m2_q;
  logic [MW-1:0] x_full;
  logic [EXP_TERMS-1:0] x_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      m1_vld_q <= 1'b0;
      m2_vld_q <= 1'b0;
    end else if (en_i) begin
      rd_vld_q <= sq_vld_q[QW-1];
      m1_vld_q <= rd_vld_q;
      m2_vld_q <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd_q      <= (sq_rem_q[QW-1] > RW'(sq_r_q[QW-1])) ? sq_r_q[QW-1] + QW'(1)
                                                        : sq_r_q[QW-1];
      rd_side_q <= sq_side_q[QW-1];
      m1_q      <= AW'(gain_i) * AW'(rd_q);
      m1_dep_q  <= rd_q;
      m1_side_q <= rd_side_q;
      m2_q      <= MW'(m1_q) * MW'(ATTN_SCALE);
      m2_dep_q  <= m1_dep_q;
      m2_side_q <= m1_side_q;
    end
  end

  assign x_full = (m2_q + (MW'(1) << (7 + FRAC_BITS))) >> (8 + FRAC_BITS);
  assign x_sat  = (x_full > MW'({EXP_TERMS{1'b1}})) ? {EXP_TERMS{1'b1}}
                                                    : x_full[EXP_TERMS-1:0];

  // exp(-x), one factor per stage
  logic [AW-1:0]        ex_acc_q  [EXP_TERMS];
  logic [EXP_TERMS-1:0] ex_x_q    [EXP_TERMS];
  logic [QW-1:0]        ex_dep_q  [EXP_TERMS];
  logic [SW-1:0]        ex_side_q [EXP_TERMS];
  logic                 ex_vld_q  [EXP_TERMS];

  for (genvar k = 0; k < EXP_TERMS; k++) begin : g_exp
    logic [AW-1:0]        acc_in;
    logic [EXP_TERMS-1:0] x_in;
    logic [QW-1:0]        dep_in;
    logic [SW-1:0]        side_in;
    logic                 vld_in;
    logic [2*AW-1:0]      prod;

    if (k == 0) begin : g_first
      assign acc_in  = AW'(1) << 30;
      assign x_in    = x_sat;
      assign dep_in  = m2_dep_q;
      assign side_in = m2_side_q;
      assign vld_in  = m2_vld_q;
    end else begin : g_next
      assign acc_in  = ex_acc_q[k-1];
      assign x_in    = ex_x_q[k-1];
      assign dep_in  = ex_dep_q[k-1];
      assign side_in = ex_side_q[k-1];
      assign vld_in  = ex_vld_q[k-1];
    end

    assign prod = (2*AW)'(acc_in) * (2*AW)'(EXP_NEG_POW2[k]) + ((2*AW)'(1) << 29);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ex_vld_q[k] <= 1'b0;
      end else if (en_i) begin
        ex_vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ex_acc_q[k]  <= x_in[k] ? prod[30 +: AW] : acc_in;
        ex_x_q[k]    <= x_in;
        ex_dep_q[k]  <= dep_in;
        ex_side_q[k] <= side_in;
      end
    end
  end

  logic [AW:0]   a_sum;
  logic [QW-1:0] a_q, d_q;
  logic [SW-1:0] fin_side_q;
  logic          fin_vld_q;

  assign a_sum = (AW+1)'(ex_acc_q[EXP_TERMS-1]) + ((AW+1)'(1) << (29 - FRAC_BITS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_vld_q <= 1'b0;
    end else if (en_i) begin
      fin_vld_q <= ex_vld_q[EXP_TERMS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q        <= a_sum[(30 - FRAC_BITS) +: QW];
      d_q        <= ex_dep_q[EXP_TERMS-1];
      fin_side_q <= ex_side_q[EXP_TERMS-1];
    end
  end

  assign vld_o  = fin_vld_q;
  assign d_o    = d_q;
  assign a_o    = a_q;
  assign side_o = fin_side_q;

endmodule

`default_nettype wire
